@@ rtl/apba_pkg.sv @@
// Shared constants, micro-operation codes and controller/datapath bundles for the allocator.
package apba_pkg;

  // Table geometry
  localparam int MAX_POOLS    = 8;
  localparam int BLOCKS       = 16;
  localparam int STRIDES      = 16;
  localparam int PIDX_W       = $clog2(MAX_POOLS);
  localparam int BIDX_W       = $clog2(BLOCKS);
  localparam int SIDX_W       = $clog2(STRIDES);
  localparam int BCNT_W       = $clog2(BLOCKS + 1);
  localparam int SCNT_W       = $clog2(STRIDES + 1);
  localparam int POPEN_W      = $clog2(MAX_POOLS + 1);
  localparam int FB_AW        = PIDX_W + BIDX_W;
  localparam int ST_AW        = PIDX_W + SIDX_W;
  localparam int FB_DEPTH     = MAX_POOLS * BLOCKS;
  localparam int ST_DEPTH     = MAX_POOLS * STRIDES;

  // Remainder unit
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CNT_W    = 6;

  // Configuration
  localparam int CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PSIZE = 2'd1;
  localparam logic [3:0]  MULT_RESET  = 4'd3;
  localparam logic [31:0] PSIZE_RESET = 32'd67108864;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_POOL = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;

  // Datapath micro-operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
  localparam logic [OP_W-1:0] OP_SCAN_INIT = 5'd2;
  localparam logic [OP_W-1:0] OP_NEXT_POOL = 5'd3;
  localparam logic [OP_W-1:0] OP_RD_BLK    = 5'd4;
  localparam logic [OP_W-1:0] OP_DIV_GO    = 5'd5;
  localparam logic [OP_W-1:0] OP_EVAL      = 5'd6;
  localparam logic [OP_W-1:0] OP_NEW_POOL  = 5'd7;
  localparam logic [OP_W-1:0] OP_SI_INIT   = 5'd8;
  localparam logic [OP_W-1:0] OP_SI_RD     = 5'd9;
  localparam logic [OP_W-1:0] OP_SI_WR_NEW = 5'd10;
  localparam logic [OP_W-1:0] OP_SI_SHIFT  = 5'd11;
  localparam logic [OP_W-1:0] OP_GRANT     = 5'd12;
  localparam logic [OP_W-1:0] OP_DROP      = 5'd13;
  localparam logic [OP_W-1:0] OP_F_INIT    = 5'd14;
  localparam logic [OP_W-1:0] OP_FS_RD     = 5'd15;
  localparam logic [OP_W-1:0] OP_FS_STEP   = 5'd16;
  localparam logic [OP_W-1:0] OP_FS_HIT    = 5'd17;
  localparam logic [OP_W-1:0] OP_F_ADD     = 5'd18;
  localparam logic [OP_W-1:0] OP_F_OFF     = 5'd19;
  localparam logic [OP_W-1:0] OP_FD_RD     = 5'd20;
  localparam logic [OP_W-1:0] OP_FD_WR     = 5'd21;
  localparam logic [OP_W-1:0] OP_FD_END    = 5'd22;
  localparam logic [OP_W-1:0] OP_FA        = 5'd23;
  localparam logic [OP_W-1:0] OP_MR_SKIP   = 5'd24;
  localparam logic [OP_W-1:0] OP_MR_RD     = 5'd25;
  localparam logic [OP_W-1:0] OP_MW        = 5'd26;
  localparam logic [OP_W-1:0] OP_MC        = 5'd27;
  localparam logic [OP_W-1:0] OP_RES       = 5'd28;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      code;
    logic            grant;
  } cmd_t;

  typedef struct packed {
    logic size_ovf;
    logic is_free;
    logic fp_bad;
    logic at_pool_end;
    logic at_blk_end;
    logic div_done;
    logic fits;
    logic pad_zero;
    logic found;
    logic pools_full;
    logic stc_full;
    logic si_zero;
    logic st_lt;
    logic fs_end;
    logic fs_less;
    logic size_zero;
    logic blk_full;
    logic hit;
    logic sd_end;
    logic mr_end;
    logic i_is_t;
    logic adj;
    logic need_copy;
    logic newsize_zero;
  } stat_t;

endpackage

@@ rtl/aligned_pool_block_allocator_top.sv @@
// Top level of the pooled free-list byte-range allocator.
//
// Usage: raise start with an allocate or free transaction on the in_ ports;
// it is taken at a clock edge where busy is low. One result per transaction
// appears on the out_ ports for a single cycle, marked by out_valid; the
// receiver cannot hold it off, so capture it when out_valid is high.
// Configuration (multiplier, default pool size) is written through cfg_we,
// cfg_index and cfg_data while busy is low and no result is pending.
// Work per transaction: an allocate runs the bit-serial 32-step remainder unit
// once for each free block it visits, steps over the pools in turn, shifts
// stride entries when padding is recorded, then checks, grants and reports.
// A free searches and shifts the stride entries of its pool; on each merge
// pass the tracked block is skipped, any other block is read and compared, a
// merge writes the joined block and may copy the last one, and every merge
// restarts the pass.
// One transaction is in flight at a time; busy stays high from the cycle after
// acceptance up to the cycle before the result, so the next transaction can be
// taken at the edge that ends the result cycle.
// Reset (synchronous, active low) empties every pool and table count and
// restores the configuration defaults; table memories need no clearing.
module aligned_pool_block_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [31:0]                    in_req_bytes,
  input  logic [15:0]                    in_align_bytes,
  input  logic                           in_is_dynamic,
  input  logic [2:0]                     in_free_pool,
  input  logic [31:0]                    in_free_offset,
  output logic                           out_valid,
  output logic [2:0]                     out_granted_pool,
  output logic [31:0]                    out_granted_offset,
  output logic [1:0]                     out_status,
  input  logic                           cfg_we,
  input  logic [apba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import apba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  apba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  apba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_op),
    .in_req_bytes       (in_req_bytes),
    .in_align_bytes     (in_align_bytes),
    .in_is_dynamic      (in_is_dynamic),
    .in_free_pool       (in_free_pool),
    .in_free_offset     (in_free_offset),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_granted_pool   (out_granted_pool),
    .out_granted_offset (out_granted_offset),
    .out_status         (out_status)
  );

endmodule

@@ rtl/apba_rem.sv @@
// Bit-serial remainder unit: 32-bit dividend modulo a 16-bit divisor, one bit a cycle.
module apba_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);
  import apba_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [31:0]          q_r;
  logic [15:0]          rem_r;
  logic [16:0]          trial;

  assign trial = {rem_r, q_r[31]};

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == DIV_CNT_W'(1));
      end
    end
  end

  // Shift in one dividend bit, subtract when the trial reaches the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[30:0], 1'b0};
      rem_r <= (trial >= {1'b0, divisor}) ? 16'(trial - {1'b0, divisor}) : trial[15:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/apba_dp.sv @@
// Datapath: request registers, block and stride tables, counters and result registers.
module apba_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  apba_pkg::cmd_t                       cmd,
  output apba_pkg::stat_t                      stat,
  input  logic                                 in_op,
  input  logic [31:0]                          in_req_bytes,
  input  logic [15:0]                          in_align_bytes,
  input  logic                                 in_is_dynamic,
  input  logic [2:0]                           in_free_pool,
  input  logic [31:0]                          in_free_offset,
  input  logic                                 cfg_we,
  input  logic [apba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic                                 out_valid,
  output logic [2:0]                           out_granted_pool,
  output logic [31:0]                          out_granted_offset,
  output logic [1:0]                           out_status
);
  import apba_pkg::*;

  // Configuration
  logic [3:0]  mult_r;
  logic [31:0] psize_r;

  // Request
  logic               op_r;
  logic [35:0]        size_r;
  logic [15:0]        align_r;
  logic [PIDX_W-1:0]  fp_r;
  logic [31:0]        foff_r;

  // Scan and grant
  logic [POPEN_W-1:0] p_r;
  logic [BCNT_W-1:0]  b_r;
  logic               found_r;
  logic [PIDX_W-1:0]  bp_r;
  logic [BIDX_W-1:0]  bb_r;
  logic [31:0]        best_noff_r;
  logic [15:0]        best_pad_r;
  logic [31:0]        best_size_r;

  // Table counts
  logic [BCNT_W-1:0]  fbc_r [MAX_POOLS];
  logic [SCNT_W-1:0]  stc_r [MAX_POOLS];
  logic [POPEN_W-1:0] popen_r;

  // Stride and merge walk
  logic [SCNT_W-1:0]  i_r;
  logic [SCNT_W-1:0]  s_r;
  logic               hit_r;
  logic [15:0]        pad_r;
  logic [BIDX_W-1:0]  t_r;
  logic [31:0]        to_r;
  logic [31:0]        ts_r;
  logic [BIDX_W-1:0]  d_r;

  // Memories
  logic [63:0] fb_mem [FB_DEPTH];
  logic [47:0] st_mem [ST_DEPTH];
  logic [63:0] fb_rd_r;
  logic [47:0] st_rd_r;
  logic              fb_re, fb_we, st_re, st_we;
  logic [FB_AW-1:0]  fb_ra, fb_wa;
  logic [ST_AW-1:0]  st_ra, st_wa;
  logic [63:0]       fb_wd;
  logic [47:0]       st_wd;

  // Results
  logic        out_valid_r;
  logic [2:0]  out_pool_r;
  logic [31:0] out_off_r;
  logic [1:0]  out_status_r;

  // Remainder unit
  logic        div_done;
  logic [15:0] rem;

  // Derived values
  logic [31:0]       size32, rd_off, rd_size, st_rd_off;
  logic [15:0]       st_rd_pad, pad_c;
  logic              fits_c, adj1, adj2;
  logic [31:0]       newsize_c, newoff_c, cap_c;
  logic [BIDX_W-1:0] last_fp, last_bp, a_c, dd_c, fin_c;
  logic [63:0]       merged_c;
  logic [PIDX_W-1:0] p_idx;

  assign size32    = size_r[31:0];
  assign rd_off    = fb_rd_r[63:32];
  assign rd_size   = fb_rd_r[31:0];
  assign st_rd_off = st_rd_r[47:16];
  assign st_rd_pad = st_rd_r[15:0];
  assign p_idx     = p_r[PIDX_W-1:0];

  apba_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV_GO),
    .dividend (rd_off),
    .divisor  (align_r),
    .done     (div_done),
    .rem      (rem)
  );

  // Fit test of the block under evaluation
  always_comb begin
    pad_c  = (rem == '0) ? 16'd0 : 16'(align_r - rem);
    fits_c = ({1'b0, size32} + {17'd0, pad_c}) <= {1'b0, rd_size};
  end

  // Carve the chosen block and size a new pool
  always_comb begin
    newsize_c = best_size_r - size32 - {16'd0, best_pad_r};
    newoff_c  = best_noff_r + size32;
    cap_c     = (size32 > psize_r) ? size32 : psize_r;
    last_bp   = BIDX_W'(fbc_r[bp_r] - 1'b1);
  end

  // Merge of the tracked block with a touching neighbour
  always_comb begin
    adj1     = ({1'b0, rd_off} + {1'b0, rd_size}) == {1'b0, to_r};
    adj2     = ({1'b0, to_r} + {1'b0, ts_r}) == {1'b0, rd_off};
    last_fp  = BIDX_W'(fbc_r[fp_r] - 1'b1);
    a_c      = adj1 ? i_r[BIDX_W-1:0] : t_r;
    dd_c     = adj1 ? t_r : i_r[BIDX_W-1:0];
    fin_c    = (a_c == last_fp) ? dd_c : a_c;
    merged_c = adj1 ? {rd_off, 32'(rd_size + ts_r)} : {to_r, 32'(ts_r + rd_size)};
  end

  // Memory port selection
  always_comb begin
    fb_re = 1'b0; fb_ra = '0;
    fb_we = 1'b0; fb_wa = '0; fb_wd = '0;
    st_re = 1'b0; st_ra = '0;
    st_we = 1'b0; st_wa = '0; st_wd = '0;
    unique case (cmd.op)
      OP_RD_BLK: begin
        fb_re = 1'b1; fb_ra = {p_idx, b_r[BIDX_W-1:0]};
      end
      OP_GRANT: begin
        if (newsize_c == '0) begin
          fb_re = 1'b1; fb_ra = {bp_r, last_bp};
        end else begin
          fb_we = 1'b1; fb_wa = {bp_r, bb_r}; fb_wd = {newoff_c, newsize_c};
        end
      end
      OP_DROP: begin
        fb_we = 1'b1; fb_wa = {bp_r, bb_r}; fb_wd = fb_rd_r;
      end
      OP_FA: begin
        fb_we = 1'b1; fb_wa = {fp_r, fbc_r[fp_r][BIDX_W-1:0]}; fb_wd = {foff_r, size32};
      end
      OP_MR_RD: begin
        fb_re = 1'b1; fb_ra = {fp_r, i_r[BIDX_W-1:0]};
      end
      OP_MW: begin
        fb_we = 1'b1; fb_wa = {fp_r, fin_c}; fb_wd = merged_c;
        fb_re = 1'b1; fb_ra = {fp_r, last_fp};
      end
      OP_MC: begin
        fb_we = 1'b1; fb_wa = {fp_r, d_r}; fb_wd = fb_rd_r;
      end
      OP_SI_RD: begin
        st_re = 1'b1; st_ra = {bp_r, SIDX_W'(i_r - 1'b1)};
      end
      OP_SI_WR_NEW: begin
        st_we = 1'b1; st_wa = {bp_r, i_r[SIDX_W-1:0]}; st_wd = {best_noff_r, best_pad_r};
      end
      OP_SI_SHIFT: begin
        st_we = 1'b1; st_wa = {bp_r, i_r[SIDX_W-1:0]}; st_wd = st_rd_r;
      end
      OP_FS_RD: begin
        st_re = 1'b1; st_ra = {fp_r, s_r[SIDX_W-1:0]};
      end
      OP_FD_RD: begin
        st_re = 1'b1; st_ra = {fp_r, SIDX_W'(s_r + 1'b1)};
      end
      OP_FD_WR: begin
        st_we = 1'b1; st_wa = {fp_r, s_r[SIDX_W-1:0]}; st_wd = st_rd_r;
      end
      default: begin
      end
    endcase
  end

  // Table memories with registered reads
  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_wa] <= fb_wd;
    if (fb_re) fb_rd_r <= fb_mem[fb_ra];
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) st_rd_r <= st_mem[st_ra];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= MULT_RESET;
      psize_r <= PSIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MULT)  mult_r  <= cfg_data[3:0];
      if (cfg_index == CFG_PSIZE) psize_r <= cfg_data;
    end
  end

  // Control state: counts, found and hit flags and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      popen_r     <= '0;
      found_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_POOLS; k++) begin
        fbc_r[k] <= '0;
        stc_r[k] <= '0;
      end
    end else begin
      out_valid_r <= (cmd.op == OP_RES);
      unique case (cmd.op)
        OP_SCAN_INIT: found_r <= 1'b0;
        OP_EVAL:      if (fits_c) found_r <= 1'b1;
        OP_NEW_POOL: begin
          fbc_r[popen_r[PIDX_W-1:0]] <= BCNT_W'(1);
          stc_r[popen_r[PIDX_W-1:0]] <= '0;
          popen_r <= popen_r + 1'b1;
        end
        OP_SI_WR_NEW: stc_r[bp_r] <= stc_r[bp_r] + 1'b1;
        OP_DROP:      fbc_r[bp_r] <= fbc_r[bp_r] - 1'b1;
        OP_F_INIT:    hit_r <= 1'b0;
        OP_FS_HIT:    hit_r <= (st_rd_off == foff_r);
        OP_FD_END:    stc_r[fp_r] <= stc_r[fp_r] - 1'b1;
        OP_FA:        fbc_r[fp_r] <= fbc_r[fp_r] + 1'b1;
        OP_MW:        fbc_r[fp_r] <= fbc_r[fp_r] - 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        op_r    <= in_op;
        size_r  <= in_is_dynamic ? (36'(in_req_bytes) * 36'(mult_r)) : 36'(in_req_bytes);
        align_r <= (in_align_bytes == '0) ? 16'd1 : in_align_bytes;
        fp_r    <= in_free_pool;
        foff_r  <= in_free_offset;
      end
      OP_SCAN_INIT: begin
        p_r <= '0;
        b_r <= '0;
      end
      OP_NEXT_POOL: begin
        p_r <= p_r + 1'b1;
        b_r <= '0;
      end
      OP_EVAL: begin
        if (fits_c) begin
          bp_r        <= p_idx;
          bb_r        <= b_r[BIDX_W-1:0];
          best_noff_r <= rd_off + {16'd0, pad_c};
          best_pad_r  <= pad_c;
          best_size_r <= rd_size;
        end
        b_r <= b_r + 1'b1;
      end
      OP_NEW_POOL: begin
        bp_r        <= popen_r[PIDX_W-1:0];
        bb_r        <= '0;
        best_noff_r <= '0;
        best_pad_r  <= '0;
        best_size_r <= cap_c;
      end
      OP_SI_INIT:  i_r <= stc_r[bp_r];
      OP_SI_SHIFT: i_r <= i_r - 1'b1;
      OP_F_INIT:   s_r <= '0;
      OP_FS_STEP:  s_r <= s_r + 1'b1;
      OP_FS_HIT:   pad_r <= st_rd_pad;
      OP_F_ADD:    if (hit_r) size_r <= size_r + 36'(pad_r);
      OP_F_OFF:    foff_r <= foff_r - {16'd0, pad_r};
      OP_FD_WR:    s_r <= s_r + 1'b1;
      OP_FA: begin
        t_r  <= fbc_r[fp_r][BIDX_W-1:0];
        to_r <= foff_r;
        ts_r <= size32;
        i_r  <= '0;
      end
      OP_MR_SKIP:  i_r <= i_r + 1'b1;
      OP_MW: begin
        t_r  <= fin_c;
        to_r <= merged_c[63:32];
        ts_r <= merged_c[31:0];
        d_r  <= dd_c;
        i_r  <= '0;
      end
      OP_RES: begin
        out_pool_r   <= cmd.grant ? bp_r : 3'd0;
        out_off_r    <= cmd.grant ? best_noff_r : 32'd0;
        out_status_r <= cmd.code;
      end
      default: begin
      end
    endcase
  end

  // Status towards the controller
  always_comb begin
    stat.size_ovf     = (size_r[35:32] != '0);
    stat.is_free      = op_r;
    stat.fp_bad       = ({1'b0, fp_r} >= popen_r);
    stat.at_pool_end  = (p_r == popen_r);
    stat.at_blk_end   = (b_r == fbc_r[p_idx]);
    stat.div_done     = div_done;
    stat.fits         = fits_c;
    stat.pad_zero     = (pad_c == '0);
    stat.found        = found_r;
    stat.pools_full   = (popen_r >= POPEN_W'(MAX_POOLS));
    stat.stc_full     = (stc_r[bp_r] >= SCNT_W'(STRIDES));
    stat.si_zero      = (i_r == '0);
    stat.st_lt        = (st_rd_off < best_noff_r);
    stat.fs_end       = (s_r == stc_r[fp_r]);
    stat.fs_less      = (st_rd_off < foff_r);
    stat.size_zero    = (size_r == '0);
    stat.blk_full     = (fbc_r[fp_r] >= BCNT_W'(BLOCKS));
    stat.hit          = hit_r;
    stat.sd_end       = ({1'b0, s_r} + 1'b1) >= {1'b0, stc_r[fp_r]};
    stat.mr_end       = (i_r == fbc_r[fp_r]);
    stat.i_is_t       = (i_r == {1'b0, t_r});
    stat.adj          = adj1 || adj2;
    stat.need_copy    = (a_c != last_fp) && (dd_c != last_fp);
    stat.newsize_zero = (newsize_c == '0);
  end

  assign out_valid          = out_valid_r;
  assign out_granted_pool   = out_pool_r;
  assign out_granted_offset = out_off_r;
  assign out_status         = out_status_r;

endmodule

@@ rtl/apba_ctrl.sv @@
// Controller: sequences allocate and free transactions over the datapath.
module apba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  apba_pkg::stat_t  stat,
  output apba_pkg::cmd_t   cmd
);
  import apba_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_AR    = 5'd2;
  localparam logic [4:0] S_AW    = 5'd3;
  localparam logic [4:0] S_DIV   = 5'd4;
  localparam logic [4:0] S_EV    = 5'd5;
  localparam logic [4:0] S_NEW   = 5'd6;
  localparam logic [4:0] S_SI0   = 5'd7;
  localparam logic [4:0] S_SI    = 5'd8;
  localparam logic [4:0] S_SIW   = 5'd9;
  localparam logic [4:0] S_GRANT = 5'd10;
  localparam logic [4:0] S_DROP  = 5'd11;
  localparam logic [4:0] S_FS    = 5'd12;
  localparam logic [4:0] S_FSW   = 5'd13;
  localparam logic [4:0] S_FC    = 5'd14;
  localparam logic [4:0] S_FC2   = 5'd15;
  localparam logic [4:0] S_FD    = 5'd16;
  localparam logic [4:0] S_FDW   = 5'd17;
  localparam logic [4:0] S_FA    = 5'd18;
  localparam logic [4:0] S_MR    = 5'd19;
  localparam logic [4:0] S_MW    = 5'd20;
  localparam logic [4:0] S_MC    = 5'd21;
  localparam logic [4:0] S_RES   = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;
  logic       grant_r, grant_nxt;

  // Next state and micro-operation
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    grant_nxt = grant_r;
    cmd.op    = OP_NONE;
    cmd.code  = code_r;
    cmd.grant = grant_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        grant_nxt = 1'b0;
        if (stat.size_ovf) begin
          code_nxt = ST_OVF; state_nxt = S_RES;
        end else if (stat.is_free) begin
          if (stat.fp_bad) begin
            code_nxt = ST_NO_POOL; state_nxt = S_RES;
          end else begin
            cmd.op = OP_F_INIT; state_nxt = S_FS;
          end
        end else begin
          cmd.op = OP_SCAN_INIT; state_nxt = S_AR;
        end
      end
      S_AR: begin
        if (stat.at_pool_end) begin
          state_nxt = stat.found ? S_SI0 : S_NEW;
        end else if (stat.at_blk_end) begin
          cmd.op = OP_NEXT_POOL;
        end else begin
          cmd.op = OP_RD_BLK; state_nxt = S_AW;
        end
      end
      S_AW: begin
        cmd.op = OP_DIV_GO; state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_EV;
      end
      S_EV: begin
        cmd.op    = OP_EVAL;
        state_nxt = (stat.fits && stat.pad_zero) ? S_GRANT : S_AR;
      end
      S_NEW: begin
        if (stat.pools_full) begin
          code_nxt = ST_NO_POOL; state_nxt = S_RES;
        end else begin
          cmd.op = OP_NEW_POOL; state_nxt = S_GRANT;
        end
      end
      S_SI0: begin
        if (stat.stc_full) begin
          code_nxt = ST_FULL; state_nxt = S_RES;
        end else begin
          cmd.op = OP_SI_INIT; state_nxt = S_SI;
        end
      end
      S_SI: begin
        if (stat.si_zero) begin
          cmd.op = OP_SI_WR_NEW; state_nxt = S_GRANT;
        end else begin
          cmd.op = OP_SI_RD; state_nxt = S_SIW;
        end
      end
      S_SIW: begin
        if (stat.st_lt) begin
          cmd.op = OP_SI_WR_NEW; state_nxt = S_GRANT;
        end else begin
          cmd.op = OP_SI_SHIFT; state_nxt = S_SI;
        end
      end
      S_GRANT: begin
        cmd.op    = OP_GRANT;
        code_nxt  = ST_OK;
        grant_nxt = 1'b1;
        state_nxt = stat.newsize_zero ? S_DROP : S_RES;
      end
      S_DROP: begin
        cmd.op = OP_DROP; state_nxt = S_RES;
      end
      S_FS: begin
        if (stat.fs_end) begin
          state_nxt = S_FC;
        end else begin
          cmd.op = OP_FS_RD; state_nxt = S_FSW;
        end
      end
      S_FSW: begin
        if (stat.fs_less) begin
          cmd.op = OP_FS_STEP; state_nxt = S_FS;
        end else begin
          cmd.op = OP_FS_HIT; state_nxt = S_FC;
        end
      end
      S_FC: begin
        cmd.op = OP_F_ADD; state_nxt = S_FC2;
      end
      S_FC2: begin
        if (stat.size_ovf) begin
          code_nxt = ST_OVF; state_nxt = S_RES;
        end else if (!stat.size_zero && stat.blk_full) begin
          code_nxt = ST_FULL; state_nxt = S_RES;
        end else if (stat.hit) begin
          cmd.op = OP_F_OFF; state_nxt = S_FD;
        end else begin
          state_nxt = S_FA;
        end
      end
      S_FD: begin
        if (stat.sd_end) begin
          cmd.op = OP_FD_END; state_nxt = S_FA;
        end else begin
          cmd.op = OP_FD_RD; state_nxt = S_FDW;
        end
      end
      S_FDW: begin
        cmd.op = OP_FD_WR; state_nxt = S_FD;
      end
      S_FA: begin
        code_nxt = ST_OK;
        if (stat.size_zero) begin
          state_nxt = S_RES;
        end else begin
          cmd.op = OP_FA; state_nxt = S_MR;
        end
      end
      S_MR: begin
        if (stat.mr_end) begin
          state_nxt = S_RES;
        end else if (stat.i_is_t) begin
          cmd.op = OP_MR_SKIP;
        end else begin
          cmd.op = OP_MR_RD; state_nxt = S_MW;
        end
      end
      S_MW: begin
        if (!stat.adj) begin
          cmd.op = OP_MR_SKIP; state_nxt = S_MR;
        end else begin
          cmd.op    = OP_MW;
          state_nxt = stat.need_copy ? S_MC : S_MR;
        end
      end
      S_MC: begin
        cmd.op = OP_MC; state_nxt = S_MR;
      end
      S_RES: begin
        cmd.op = OP_RES; state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and pending result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
      grant_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      grant_r <= grant_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the pooled free-list byte-range allocator.
`timescale 1ns / 1ps

module testbench;
  import apba_pkg::*;

  localparam int  STALL_LIMIT = 200000;
  localparam int  ITEMS_PER_PHASE = 310;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;

  typedef struct {
    bit          op;
    logic [31:0] req;
    logic [15:0] align;
    bit          dyn;
    logic [2:0]  fpool;
    logic [31:0] foff;
  } alloc_txn_t;

  typedef struct {
    logic [2:0]  pool;
    logic [31:0] off;
    logic [1:0]  st;
  } grant_t;

  typedef struct {
    bit          op;
    logic [31:0] req;
    logic [15:0] align;
    bit          dyn;
    logic [2:0]  fpool;
    logic [31:0] foff;
    bit          known;
    logic [2:0]  epool;
    logic [31:0] eoff;
    logic [1:0]  est;
  } dir_row_t;

  typedef struct {
    logic [2:0]  pool;
    logic [31:0] off;
    logic [31:0] req;
    bit          dyn;
  } live_range_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [31:0] in_req_bytes = '0;
  logic [15:0] in_align_bytes = '0;
  logic in_is_dynamic = 1'b0;
  logic [2:0] in_free_pool = '0;
  logic [31:0] in_free_offset = '0;
  logic out_valid;
  logic [2:0] out_granted_pool;
  logic [31:0] out_granted_offset;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  aligned_pool_block_allocator_top dut (.*);

  always #5 clk = ~clk;

  // Shadow allocator state
  logic [31:0] fb_off [MAX_POOLS][BLOCKS];
  logic [31:0] fb_sz  [MAX_POOLS][BLOCKS];
  int          fb_cnt [MAX_POOLS];
  int          pools_n;
  logic [31:0] sc_at  [MAX_POOLS][STRIDES];
  logic [31:0] sc_pad [MAX_POOLS][STRIDES];
  int          sc_cnt [MAX_POOLS];
  logic [3:0]  mult_q;
  logic [31:0] psize_q;

  grant_t      grants_due [$];
  live_range_t live [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          accepted = 0;
  int          outcome_seen [4] = '{0, 0, 0, 0};

  function automatic void drop_entry(int p, int i);
    int last = fb_cnt[p] - 1;
    fb_off[p][i] = fb_off[p][last];
    fb_sz[p][i]  = fb_sz[p][last];
    fb_cnt[p]    = last;
  endfunction

  // Merge block t with any touching block, restarting the pass after each merge
  function automatic void coalesce(int p, int t);
    int i = 0;
    int idx;
    longint unsigned io, is, to, ts;
    while (i < fb_cnt[p]) begin
      io = fb_off[p][i]; is = fb_sz[p][i];
      to = fb_off[p][t]; ts = fb_sz[p][t];
      if (i != t && io + is == to) begin
        fb_sz[p][i] = 32'((is + ts) & M32);
        idx = (i == fb_cnt[p] - 1) ? t : i;
        drop_entry(p, t);
        t = idx;
        i = 0;
      end else if (i != t && to + ts == io) begin
        fb_sz[p][t] = 32'((ts + is) & M32);
        idx = (t == fb_cnt[p] - 1) ? i : t;
        drop_entry(p, i);
        t = idx;
        i = 0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic logic [1:0] carve(longint unsigned sz, longint unsigned al,
                                       output int gp, output longint unsigned go);
    int bp = 0, bb = 0, pos;
    bit found = 0, exact = 0;
    longint unsigned o, n, pad, cap;
    gp = 0;
    go = 0;
    // Keep the last fit, stop at a fit with no padding
    for (int p = 0; p < pools_n && !exact; p++) begin
      for (int b = 0; b < fb_cnt[p] && !exact; b++) begin
        o = fb_off[p][b];
        n = ((o + al - 1) / al) * al;
        pad = n - o;
        if (sz + pad <= fb_sz[p][b]) begin
          bp = p; bb = b; found = 1;
          if (pad == 0) exact = 1;
        end
      end
    end
    if (!found) begin
      if (pools_n >= MAX_POOLS) return ST_NO_POOL;
      cap = psize_q;
      if (sz > cap) cap = sz;
      bp = pools_n;
      pools_n++;
      bb = 0;
      exact = 1;
      fb_off[bp][0] = '0;
      fb_sz[bp][0]  = 32'(cap);
      fb_cnt[bp]    = 1;
      sc_cnt[bp]    = 0;
    end
    o = fb_off[bp][bb];
    n = ((o + al - 1) / al) * al;
    pad = n - o;
    // Record the padding as a stride changer, kept sorted by offset
    if (!exact) begin
      if (sc_cnt[bp] >= STRIDES) return ST_FULL;
      pos = 0;
      while (pos < sc_cnt[bp] && sc_at[bp][pos] < 32'(n & M32)) pos++;
      for (int i = sc_cnt[bp]; i > pos; i--) begin
        sc_at[bp][i]  = sc_at[bp][i-1];
        sc_pad[bp][i] = sc_pad[bp][i-1];
      end
      sc_at[bp][pos]  = 32'(n & M32);
      sc_pad[bp][pos] = 32'(pad);
      sc_cnt[bp]++;
    end
    fb_sz[bp][bb]  = 32'(longint'(fb_sz[bp][bb]) - (sz + pad));
    fb_off[bp][bb] = 32'((n + sz) & M32);
    if (fb_sz[bp][bb] == 0) drop_entry(bp, bb);
    gp = bp;
    go = n & M32;
    return ST_OK;
  endfunction

  function automatic logic [1:0] give_back(int p, logic [31:0] off, longint unsigned sz);
    int s = 0, i;
    bit hit;
    longint unsigned total = sz;
    logic [31:0] o = off;
    if (p >= pools_n) return ST_NO_POOL;
    while (s < sc_cnt[p] && sc_at[p][s] < off) s++;
    hit = s < sc_cnt[p] && sc_at[p][s] == off;
    if (hit) begin
      total += sc_pad[p][s];
      if (total > M32) return ST_OVF;
    end
    if (total != 0 && fb_cnt[p] >= BLOCKS) return ST_FULL;
    if (hit) begin
      o = off - sc_pad[p][s];
      for (int k = s; k + 1 < sc_cnt[p]; k++) begin
        sc_at[p][k]  = sc_at[p][k+1];
        sc_pad[p][k] = sc_pad[p][k+1];
      end
      sc_cnt[p]--;
    end
    if (total == 0) return ST_OK;
    i = fb_cnt[p];
    fb_cnt[p]++;
    fb_off[p][i] = o;
    fb_sz[p][i]  = 32'(total);
    coalesce(p, i);
    return ST_OK;
  endfunction

  function automatic grant_t predict_grant(alloc_txn_t t);
    grant_t r;
    longint unsigned sz = t.req;
    longint unsigned al = (t.align == 0) ? 1 : t.align;
    int gp = 0;
    longint unsigned go = 0;
    if (t.dyn) sz = sz * mult_q;
    if (sz > M32) r.st = ST_OVF;
    else if (!t.op) r.st = carve(sz, al, gp, go);
    else r.st = give_back(int'(t.fpool), t.foff, sz);
    if (r.st != ST_OK) begin
      gp = 0;
      go = 0;
    end
    r.pool = 3'(gp);
    r.off  = 32'(go);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Drive one transaction and hold it until accepted; start stays high afterwards
  task automatic issue(alloc_txn_t t, output grant_t g);
    start          <= 1'b1;
    in_op          <= t.op;
    in_req_bytes   <= t.req;
    in_align_bytes <= t.align;
    in_is_dynamic  <= t.dyn;
    in_free_pool   <= t.fpool;
    in_free_offset <= t.foff;
    do @(posedge clk); while (busy);
    g = predict_grant(t);
    grants_due.insert(grants_due.size(), g);
    accepted++;
  endtask

  task automatic sender_gap(int idle_pct);
    int gap = 0;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_MULT) mult_q = val[3:0];
    else if (idx == CFG_PSIZE) psize_q = val;
  endtask

  function automatic alloc_txn_t rand_txn();
    alloc_txn_t t;
    int pick, k;
    t.dyn   = $urandom_range(0, 3) == 0;
    t.fpool = 3'($urandom);
    t.foff  = $urandom;
    pick    = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0:       t.align = 16'($urandom);
      1:       t.align = '0;
      2, 3:    t.align = 16'($urandom_range(1, 100));
      default: t.align = 16'(1 << $urandom_range(0, 6));
    endcase
    if (pick < 88) t.req = $urandom_range(1, 64);
    else if (pick < 96) t.req = $urandom_range(65, 8192);
    else t.req = $urandom;
    if (pick < 8) begin
      // noise: free of an arbitrary range
      t.op = 1'b1;
    end else if (live.size() != 0 && $urandom_range(0, 1) == 1) begin
      k       = $urandom_range(0, live.size() - 1);
      t.op    = 1'b1;
      t.fpool = live[k].pool;
      t.foff  = live[k].off;
      t.req   = live[k].req;
      t.dyn   = live[k].dyn;
      live.delete(k);
    end else begin
      t.op = 1'b0;
    end
    return t;
  endfunction

  localparam int N_DIR = 15;
  dir_row_t dir_rows [N_DIR] = '{
    '{0, 32'd16,         16'd1,     0, 3'd0, 32'd0,          1, 3'd0, 32'd0,  ST_OK},
    '{0, 32'hFFFF_FFFF,  16'd1,     1, 3'd0, 32'd0,          1, 3'd0, 32'd0,  ST_OVF},
    '{1, 32'd8,          16'd1,     0, 3'd7, 32'd0,          1, 3'd0, 32'd0,  ST_NO_POOL},
    '{0, 32'hFFFF_FFFF,  16'hFFFF,  0, 3'd0, 32'd0,          1, 3'd1, 32'd0,  ST_OK},
    '{0, 32'd1,          16'd0,     0, 3'd0, 32'd0,          1, 3'd0, 32'd16, ST_OK},
    '{0, 32'd100,        16'd4096,  0, 3'd0, 32'd0,          0, 3'd0, 32'd0,  ST_OK},
    '{0, 32'd5,          16'd3,     1, 3'd0, 32'd0,          0, 3'd0, 32'd0,  ST_OK},
    '{1, 32'd16,         16'd1,     0, 3'd0, 32'd0,          1, 3'd0, 32'd0,  ST_OK},
    '{1, 32'd100,        16'd1,     0, 3'd0, 32'd4096,       0, 3'd0, 32'd0,  ST_OK},
    '{1, 32'd0,          16'd1,     0, 3'd1, 32'd0,          1, 3'd0, 32'd0,  ST_OK},
    '{1, 32'h20,         16'd1,     0, 3'd0, 32'hFFFF_FFF0,  0, 3'd0, 32'd0,  ST_OK},
    '{1, 32'hFFFF_FFFF,  16'd1,     1, 3'd1, 32'd0,          1, 3'd0, 32'd0,  ST_OVF},
    '{0, 32'd64,         16'hFFFF,  1, 3'd0, 32'd0,          0, 3'd0, 32'd0,  ST_OK},
    '{0, 32'd7,          16'h8000,  0, 3'd0, 32'd0,          0, 3'd0, 32'd0,  ST_OK},
    '{1, 32'd4,          16'd1,     0, 3'd5, 32'd0,          1, 3'd0, 32'd0,  ST_NO_POOL}
  };

  // Check each result against the oldest outstanding grant
  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid) begin
      if (grants_due.size() == 0) begin
        flag_mismatch("result with no transaction outstanding");
      end else begin
        e = grants_due.pop_front();
        outcome_seen[e.st]++;
        if (out_status !== e.st)
          flag_mismatch($sformatf("status %0d, expected %0d", out_status, e.st));
        if (out_granted_pool !== e.pool)
          flag_mismatch($sformatf("pool %0d, expected %0d", out_granted_pool, e.pool));
        if (out_granted_offset !== e.off)
          flag_mismatch($sformatf("offset %h, expected %h", out_granted_offset, e.off));
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    alloc_txn_t t;
    grant_t g;
    int idle_pct [3];
    logic [3:0]  mults  [3];
    logic [31:0] psizes [3];
    idle_pct = '{38, 60, 0};
    mults  = '{4'd8, 4'd1, 4'($urandom_range(2, 7))};
    psizes = '{32'd4096, 32'd1, 32'hFFFF_FFFF};
    for (int p = 0; p < MAX_POOLS; p++) begin
      fb_cnt[p] = 0;
      sc_cnt[p] = 0;
    end
    pools_n = 0;
    mult_q  = MULT_RESET;
    psize_q = PSIZE_RESET;

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table from the reset configuration
    foreach (dir_rows[r]) begin
      t = '{dir_rows[r].op, dir_rows[r].req, dir_rows[r].align, dir_rows[r].dyn,
            dir_rows[r].fpool, dir_rows[r].foff};
      issue(t, g);
      if (dir_rows[r].known &&
          (g.st != dir_rows[r].est || g.pool != dir_rows[r].epool ||
           g.off != dir_rows[r].eoff))
        flag_mismatch($sformatf("directed row %0d: predictor disagrees with table", r));
      sender_gap($urandom_range(0, 1) ? 38 : 0);
    end

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 3; ph++) begin
      drain();
      write_reg(CFG_MULT, 32'(mults[ph]));
      write_reg(CFG_PSIZE, psizes[ph]);
      live.delete();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        t = rand_txn();
        issue(t, g);
        if (!t.op && g.st == ST_OK)
          live.insert(live.size(), live_range_t'{g.pool, g.off, t.req, t.dyn});
        sender_gap(idle_pct[ph]);
      end
    end

    drain();
    $display("covered %0d transactions: ok %0d, no pool %0d, table full %0d, overflow %0d",
             accepted, outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3]);
    $display("configurations: reset defaults plus three phases with multiplier 1..8");
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/apba_pkg.sv
rtl/apba_rem.sv
rtl/apba_dp.sv
rtl/apba_ctrl.sv
rtl/aligned_pool_block_allocator_top.sv
verif/testbench.sv
